// File: rtl/core/tcc_pkg.sv
// Shared types, codes and constants for the text console cursor.
`default_nettype none
package tcc_pkg;

	localparam int unsigned TAB_STOP = 8;

	localparam int unsigned COORD_W = 15;
	localparam int unsigned COL_W   = 9;
	localparam int unsigned ROW_W   = 8;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned OUT_DATA_W = 72;

	// command kinds on tuser
	localparam logic CMD_GLYPH = 1'b0;
	localparam logic CMD_FILL  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH_PX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_PER_LINE  = 3'd6;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BEL = 8'd7;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_VT  = 8'd11;
	localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

	typedef struct packed {
		logic [9:0]  window_left;
		logic [9:0]  window_top;
		logic [10:0] window_width_px;
		logic [5:0]  glyph_width;
		logic [6:0]  glyph_height;
		logic [7:0]  line_count;
		logic [7:0]  chars_per_line;
	} cfg_t;

	// one pending command, before coordinates are worked out
	typedef struct packed {
		logic              kind;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CHAR_W-1:0] glyph;
	} desc_t;

	typedef struct packed {
		logic  valid;   // at least one command
		logic  two;     // two commands
		desc_t first;
		desc_t second;
	} item_t;

endpackage
`default_nettype wire

// File: rtl/core/tcc_config.sv
// Configuration register file of the text console cursor.
`default_nettype none
module tcc_config
	import tcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_left     <= 10'd0;
			cfg_q.window_top      <= 10'd240;
			cfg_q.window_width_px <= 11'd240;
			cfg_q.glyph_width     <= 6'd6;
			cfg_q.glyph_height    <= 7'd12;
			cfg_q.line_count      <= 8'd8;
			cfg_q.chars_per_line  <= 8'd40;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WINDOW_LEFT:     cfg_q.window_left     <= cfg_data[9:0];
				REG_WINDOW_TOP:      cfg_q.window_top      <= cfg_data[9:0];
				REG_WINDOW_WIDTH_PX: cfg_q.window_width_px <= cfg_data[10:0];
				REG_GLYPH_WIDTH:     cfg_q.glyph_width     <= cfg_data[5:0];
				REG_GLYPH_HEIGHT:    cfg_q.glyph_height    <= cfg_data[6:0];
				REG_LINE_COUNT:      cfg_q.line_count      <= cfg_data[7:0];
				REG_CHARS_PER_LINE:  cfg_q.chars_per_line  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/tcc_cursor.sv
// Cursor state and per-character command decode.
`default_nettype none
module tcc_cursor
	import tcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              accept,
	input  wire logic [CHAR_W-1:0] char_code,
	output item_t                  item
);

	logic [COL_W-1:0] col_q, col_a, col_d;
	logic [ROW_W-1:0] row_q, row_a, row_d;
	logic             force_nl;
	logic             has_act;
	desc_t            act, fill_a;

	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
		input logic [7:0] lc);
		logic [ROW_W:0] inc;
		inc = {1'b0, r} + 9'd1;
		return (inc >= {1'b0, lc}) ? '0 : inc[ROW_W-1:0];
	endfunction

	always_comb begin
		force_nl = col_q >= {1'b0, cfg.chars_per_line};
		col_a    = force_nl ? '0 : col_q;
		row_a    = force_nl ? next_row(row_q, cfg.line_count) : row_q;

		fill_a.kind  = CMD_FILL;
		fill_a.col   = '0;
		fill_a.row   = row_a;
		fill_a.glyph = '0;

		has_act   = 1'b0;
		act.kind  = CMD_GLYPH;
		act.col   = col_a;
		act.row   = row_a;
		act.glyph = char_code;
		col_d     = col_a;
		row_d     = row_a;

		unique case (char_code)
			CH_BEL, CH_VT, CH_FF: ;
			CH_BS: begin
				if (col_a != '0) col_d = col_a - 9'd1;
			end
			CH_TAB: begin
				col_d = COL_W'((col_a / TAB_STOP + 1) * TAB_STOP);
			end
			CH_LF, CH_CR: begin
				has_act   = 1'b1;
				row_d     = next_row(row_a, cfg.line_count);
				col_d     = '0;
				act.kind  = CMD_FILL;
				act.col   = '0;
				act.row   = row_d;
				act.glyph = '0;
			end
			default: begin
				has_act = 1'b1;
				col_d   = col_a + 9'd1;
			end
		endcase

		item.valid  = force_nl | has_act;
		item.two    = force_nl & has_act;
		item.first  = force_nl ? fill_a : act;
		item.second = act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/tcc_emit.sv
// Command slot register, coordinate arithmetic and output register.
`default_nettype none
module tcc_emit
	import tcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cfg_t                       cfg,
	input  wire logic                  in_valid,
	input  item_t                      in_item,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_DATA_W-1:0]      out_data,
	output logic                       out_kind,
	output logic                       out_last
);

	logic             valid_s1;
	logic             two_s1;
	logic             idx_s1;
	desc_t            desc_s1 [2];

	logic             out_valid_q;
	logic             kind_q, last_q;
	logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [CHAR_W-1:0]  glyph_q;

	logic             load, take, slot_last, accept;
	desc_t            d;
	logic [COORD_W-1:0] prod_x, prod_y;
	logic [16:0]      gx, gy, fy1, fx1;

	assign load      = !out_valid_q || out_ready;
	assign take      = valid_s1 && load;
	assign slot_last = !two_s1 || idx_s1;
	assign in_ready  = !valid_s1 || (take && slot_last);
	assign accept    = in_valid && in_ready;

	always_comb begin
		d      = desc_s1[idx_s1];
		prod_x = COORD_W'(d.col * cfg.glyph_width);
		prod_y = COORD_W'(d.row * cfg.glyph_height);
		gx     = 17'(prod_x) + 17'(cfg.window_left);
		gy     = 17'(prod_y) + 17'(cfg.window_top);
		fy1    = gy + 17'(cfg.glyph_height);
		fx1    = 17'(cfg.window_left) + 17'(cfg.window_width_px);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= 1'b0;
		end else begin
			if (accept && in_item.valid) begin
				valid_s1 <= 1'b1;
				idx_s1   <= 1'b0;
			end else if (take && slot_last) begin
				valid_s1 <= 1'b0;
			end else if (take) begin
				idx_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.valid) begin
			two_s1     <= in_item.two;
			desc_s1[0] <= in_item.first;
			desc_s1[1] <= in_item.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= d.kind;
			last_q  <= slot_last;
			y0_q    <= gy[COORD_W-1:0];
			if (d.kind == CMD_FILL) begin
				x0_q    <= COORD_W'(cfg.window_left);
				x1_q    <= fx1[COORD_W-1:0];
				y1_q    <= fy1[COORD_W-1:0];
				glyph_q <= '0;
			end else begin
				x0_q    <= gx[COORD_W-1:0];
				x1_q    <= '0;
				y1_q    <= '0;
				glyph_q <= d.glyph;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {4'd0, glyph_q, y1_q, x1_q, y0_q, x0_q};

endmodule
`default_nettype wire

// File: rtl/core/text_console_cursor_top.sv
// Text console cursor: character stream in, glyph and row-clear commands out.
//
// s_axis carries one character byte per transaction. The cursor column and
// row are updated in the cycle a character is accepted; control codes are
// interpreted (backspace, tab, line feed, carriage return; bell, vertical tab
// and form feed are ignored). Each character yields zero, one or two commands
// on m_axis: an automatic newline's row clear when the line is full, then a
// glyph draw or a row clear. tlast marks the last command of one character.
// Each command passes through the slot register, then the output register. One
// command leaves per cycle while m_axis_tready is high, so printable characters
// stream at one per cycle; a character with two commands holds the slot register
// until its second one is taken. Characters producing no command emit nothing.
// When the receiver stalls, the output register holds its command, the slot
// register holds the next one, and s_axis_tready drops once both are full.
// Reset puts the cursor at column 0, row 0 and loads the default window
// registers; the config port accepts a write every cycle and must only be
// used while no commands are pending.
`default_nettype none
module text_console_cursor_top
	import tcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [7:0] char_code
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [14:0] x_start, [29:15] y_start, [44:30] x_end, [59:45] y_end,
	// [67:60] glyph_code, [71:68] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                 m_axis_tuser,  // [0] cmd_kind
	output logic                       m_axis_tlast,  // last_of_run
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item;
	logic  in_ready;
	logic  kind;

	tcc_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tcc_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (s_axis_tvalid && in_ready),
		.char_code (s_axis_tdata),
		.item      (item)
	);

	tcc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_item   (item),
		.in_ready  (in_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (kind),
		.out_last  (m_axis_tlast)
	);

	assign s_axis_tready = in_ready;
	assign m_axis_tuser  = kind;

endmodule
`default_nettype wire

// File: rtl/core/tcc_checker.sv
// Port-level assertions for the text console cursor, bound to the top level.
`default_nettype none
module tcc_checker
	import tcc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [0:0]            m_axis_tuser,
	input wire logic                  m_axis_tlast
);

	// a stalled command stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled command changed");

	// a glyph is always the final command of its character
	a_glyph_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] == CMD_GLYPH |-> m_axis_tlast)
		else $error("glyph command without tlast");

	a_glyph_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] == CMD_GLYPH |-> m_axis_tdata[59:30] == '0)
		else $error("glyph command with nonzero end corner");

	a_fill_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] == CMD_FILL |-> m_axis_tdata[67:60] == '0)
		else $error("fill command with nonzero glyph code");

endmodule

bind text_console_cursor_top tcc_checker u_tcc_checker (.*);
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the text console cursor: characters in, commands checked out.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import tcc_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 190;

	typedef struct packed {
		logic        kind;
		logic [14:0] x_start;
		logic [14:0] y_start;
		logic [14:0] x_end;
		logic [14:0] y_end;
		logic [7:0]  glyph;
		logic        last;
	} console_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the window registers and cursor
	cfg_t             win;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;

	logic [7:0]   pending_chars[$];
	console_cmd_t expected_cmds[$];

	int  errors = 0;
	bit  idle_on = 1'b1;
	bit  char_taken = 1'b0;
	bit  hold_req = 1'b0;
	int  src_gap = 0;
	int  sink_gap = 0;
	int  hold_left = 0;
	int unsigned quiet = 0;

	always #5 clk = ~clk;

	text_console_cursor_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	task automatic flag_error(input string what, input int unsigned got, input int unsigned want);
		if (errors < 50)
			$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// newline: next row with wrap, column back to zero, clear the new row
	task automatic start_new_line();
		int unsigned r;
		int unsigned y0;
		int unsigned y1;
		int unsigned x1;
		console_cmd_t c;
		r = int'(cur_row) + 1;
		if (r >= 32'(win.line_count))
			r = 0;
		cur_row = r[7:0];
		cur_col = '0;
		y0 = int'(win.window_top) + int'(cur_row) * int'(win.glyph_height);
		y1 = int'(win.window_top) + (int'(cur_row) + 1) * int'(win.glyph_height);
		x1 = int'(win.window_left) + int'(win.window_width_px);
		c = '0;
		c.kind = CMD_FILL;
		c.x_start = 15'(win.window_left);
		c.y_start = y0[14:0];
		c.x_end = x1[14:0];
		c.y_end = y1[14:0];
		expected_cmds.push_back(c);
	endtask

	task automatic track_char(input logic [7:0] ch);
		int unsigned n0;
		int unsigned t;
		int unsigned x;
		int unsigned y;
		console_cmd_t c;
		n0 = expected_cmds.size();
		if (cur_col >= {1'b0, win.chars_per_line})
			start_new_line();
		case (ch)
			CH_BEL, CH_VT, CH_FF: ;
			CH_BS: begin
				if (cur_col != '0)
					cur_col = cur_col - COL_W'(1);
			end
			CH_TAB: begin
				t = (int'(cur_col) / TAB_STOP + 1) * TAB_STOP;
				cur_col = t[COL_W-1:0];
			end
			CH_LF, CH_CR: start_new_line();
			default: begin
				x = int'(cur_col) * int'(win.glyph_width) + int'(win.window_left);
				y = int'(cur_row) * int'(win.glyph_height) + int'(win.window_top);
				c = '0;
				c.kind = CMD_GLYPH;
				c.x_start = x[14:0];
				c.y_start = y[14:0];
				c.glyph = ch;
				expected_cmds.push_back(c);
				cur_col = cur_col + COL_W'(1);
			end
		endcase
		if (expected_cmds.size() > n0) begin
			c = expected_cmds.pop_back();
			c.last = 1'b1;
			expected_cmds.push_back(c);
		end
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 55) return 8'($urandom_range(32, 126));
		if (w < 65) return 8'($urandom_range(0, 255));
		if (w < 73) return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
		if (w < 80) return CH_BS;
		if (w < 87) return CH_TAB;
		if (w < 91) begin
			case ($urandom_range(0, 2))
				0: return CH_BEL;
				1: return CH_VT;
				default: return CH_FF;
			endcase
		end
		return 8'($urandom_range(128, 255));
	endfunction

	// input driver: presents queued characters, random gaps between them
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || char_taken) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					s_axis_tdata <= pending_chars.pop_front();
					s_axis_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 3) == 0)
						src_gap = $urandom_range(1, 9);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			char_taken = 1'b0;
		end
	end

	// output sink: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 9);
		end
	end

	// monitor: config shadow, prediction on input transaction, check on output transaction
	always @(posedge clk or negedge arst_n) begin : monitor
		console_cmd_t got;
		console_cmd_t want;
		if (!arst_n) begin
			win.window_left = 10'd0;
			win.window_top = 10'd240;
			win.window_width_px = 11'd240;
			win.glyph_width = 6'd6;
			win.glyph_height = 7'd12;
			win.line_count = 8'd8;
			win.chars_per_line = 8'd40;
			cur_col = '0;
			cur_row = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LEFT:     win.window_left = cfg_data[9:0];
					REG_WINDOW_TOP:      win.window_top = cfg_data[9:0];
					REG_WINDOW_WIDTH_PX: win.window_width_px = cfg_data[10:0];
					REG_GLYPH_WIDTH:     win.glyph_width = cfg_data[5:0];
					REG_GLYPH_HEIGHT:    win.glyph_height = cfg_data[6:0];
					REG_LINE_COUNT:      win.line_count = cfg_data[7:0];
					REG_CHARS_PER_LINE:  win.chars_per_line = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_char(s_axis_tdata);
				char_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser[0];
				got.x_start = m_axis_tdata[14:0];
				got.y_start = m_axis_tdata[29:15];
				got.x_end = m_axis_tdata[44:30];
				got.y_end = m_axis_tdata[59:45];
				got.glyph = m_axis_tdata[67:60];
				got.last = m_axis_tlast;
				if (expected_cmds.size() == 0) begin
					flag_error("command with none expected, x_start", 32'(got.x_start), 0);
				end else begin
					want = expected_cmds.pop_front();
					if (got.kind != want.kind)
						flag_error("cmd_kind", 32'(got.kind), 32'(want.kind));
					if (got.x_start != want.x_start)
						flag_error("x_start", 32'(got.x_start), 32'(want.x_start));
					if (got.y_start != want.y_start)
						flag_error("y_start", 32'(got.y_start), 32'(want.y_start));
					if (got.x_end != want.x_end)
						flag_error("x_end", 32'(got.x_end), 32'(want.x_end));
					if (got.y_end != want.y_end)
						flag_error("y_end", 32'(got.y_end), 32'(want.y_end));
					if (got.glyph != want.glyph)
						flag_error("glyph_code", 32'(got.glyph), 32'(want.glyph));
					if (got.last != want.last)
						flag_error("tlast", 32'(got.last), 32'(want.last));
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_window(input int unsigned left, input int unsigned top,
	                            input int unsigned width, input int unsigned gw,
	                            input int unsigned gh, input int unsigned lines,
	                            input int unsigned cols);
		write_reg(REG_WINDOW_LEFT, left);
		write_reg(REG_WINDOW_TOP, top);
		write_reg(REG_WINDOW_WIDTH_PX, width);
		write_reg(REG_GLYPH_WIDTH, gw);
		write_reg(REG_GLYPH_HEIGHT, gh);
		write_reg(REG_LINE_COUNT, lines);
		write_reg(REG_CHARS_PER_LINE, cols);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain: no queued input, nothing in flight, then cover the no-result latency
	task automatic wait_drained();
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [7:0] first_chars[] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h41, CH_BS, CH_TAB,
		                              CH_BEL, CH_VT, CH_FF, CH_LF, CH_CR};
		// tiny window: line full, row wrap, tab past the line, LF/BS on a full line
		logic [7:0] tiny_chars[] = '{8'h61, 8'h62, 8'h63, 8'h64, CH_LF, CH_CR, CH_TAB,
		                             8'h65, 8'h78, 8'h79, CH_LF, 8'h31, 8'h32, 8'h33,
		                             CH_BS, CH_BS};
		int unsigned lines;
		int unsigned cols;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		foreach (first_chars[i]) pending_chars.push_back(first_chars[i]);
		wait_drained();

		apply_window(5, 3, 20, 4, 5, 2, 3);
		foreach (tiny_chars[i]) pending_chars.push_back(tiny_chars[i]);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_window(0, 0, 1, 1, 1, 1, 1);
				1: apply_window(1023, 1023, 1024, 32, 64, 255, 255);
				default: begin
					lines = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) :
					                                      $urandom_range(1, 12);
					cols = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) :
					                                     $urandom_range(1, 24);
					apply_window($urandom_range(0, 1023), $urandom_range(0, 1023),
					             $urandom_range(1, 1024), $urandom_range(1, 32),
					             $urandom_range(1, 64), lines, cols);
				end
			endcase
			if (p == 5)
				idle_on = 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_chars.push_back(pick_char());
			if (p == 2)
				hold_req = 1'b1;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		while (expected_cmds.size() != 0) begin
			want_left_over: begin
				console_cmd_t c;
				c = expected_cmds.pop_front();
				flag_error("missing command, x_start", 0, 32'(c.x_start));
			end
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
